// ----- sv/ddo_pkg.sv -----
package ddo_pkg;

  // default number of cordic rotations
  localparam int unsigned CORDIC_STEPS_DEF = 24;

  // field and register widths
  localparam int unsigned SPEED_W = 16;
  localparam int unsigned CFG_W   = 24;
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned ANG_W   = 32;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned FWD_W   = 26;
  localparam int unsigned TW_W    = 26;
  localparam int unsigned TD_W    = 27;
  localparam int unsigned CRD_W   = 34;

  // shared multiplier operand and product widths
  localparam int unsigned MUL_AW = 28;
  localparam int unsigned MUL_BW = 33;
  localparam int unsigned MUL_PW = MUL_AW + MUL_BW;

  // configuration reset values
  localparam logic [CFG_W-1:0] STEP_DIST_RST  = 24'd213071;
  localparam logic [CFG_W-1:0] HEAD_GAIN_RST  = 24'd1011429;
  localparam logic [CFG_W-1:0] WHEEL_GAIN_RST = 24'd4837335;

  // cordic constants, q4.30 start vector and quarter/half turn
  localparam logic signed [CRD_W-1:0] CORDIC_X0 = 34'sh0_26DD_3B6A;
  localparam logic signed [CRD_W-1:0] Q_TURN    = 34'sh0_4000_0000;
  localparam logic signed [CRD_W-1:0] H_TURN    = 34'sh0_8000_0000;

  localparam logic signed [MUL_PW-1:0] S32_MAX = MUL_PW'(64'sd2147483647);
  localparam logic signed [MUL_PW-1:0] S32_MIN = MUL_PW'(-64'sd2147483648);

  typedef enum logic [IDX_W-1:0] {
    CFG_STEP_DIST  = 2'd0,
    CFG_HEAD_GAIN  = 2'd1,
    CFG_WHEEL_GAIN = 2'd2
  } cfg_idx_e;

  typedef enum logic [15:0] {
    ST_IDLE   = 16'h0001,
    ST_MUL_L  = 16'h0002,
    ST_MUL_R  = 16'h0004,
    ST_ANG_L  = 16'h0008,
    ST_ANG_R  = 16'h0010,
    ST_FWD    = 16'h0020,
    ST_DIFF   = 16'h0040,
    ST_TD     = 16'h0080,
    ST_GAIN   = 16'h0100,
    ST_TURN   = 16'h0200,
    ST_CSTART = 16'h0400,
    ST_CWAIT  = 16'h0800,
    ST_MULX   = 16'h1000,
    ST_MULY   = 16'h2000,
    ST_POSY   = 16'h4000,
    ST_DONE   = 16'h8000
  } state_e;

  // arctangent of 2^-i in binary angle units
  function automatic logic [ANG_W-1:0] atan_lut(input logic [4:0] i);
    logic [ANG_W-1:0] v;
    case (i)
      5'd0:  v = 32'h2000_0000;
      5'd1:  v = 32'h12E4_051E;
      5'd2:  v = 32'h09FB_385B;
      5'd3:  v = 32'h0511_11D4;
      5'd4:  v = 32'h028B_0D43;
      5'd5:  v = 32'h0145_D7E1;
      5'd6:  v = 32'h00A2_F61E;
      5'd7:  v = 32'h0051_7C55;
      5'd8:  v = 32'h0028_BE53;
      5'd9:  v = 32'h0014_5F2F;
      5'd10: v = 32'h000A_2F98;
      5'd11: v = 32'h0005_17CC;
      5'd12: v = 32'h0002_8BE6;
      5'd13: v = 32'h0001_45F3;
      5'd14: v = 32'h0000_A2FA;
      5'd15: v = 32'h0000_517D;
      5'd16: v = 32'h0000_28BE;
      5'd17: v = 32'h0000_145F;
      5'd18: v = 32'h0000_0A30;
      5'd19: v = 32'h0000_0518;
      5'd20: v = 32'h0000_028C;
      5'd21: v = 32'h0000_0146;
      5'd22: v = 32'h0000_00A3;
      5'd23: v = 32'h0000_0051;
      5'd24: v = 32'h0000_0029;
      5'd25: v = 32'h0000_0014;
      5'd26: v = 32'h0000_000A;
      5'd27: v = 32'h0000_0005;
      5'd28: v = 32'h0000_0003;
      5'd29: v = 32'h0000_0001;
      5'd30: v = 32'h0000_0001;
      default: v = 32'h0000_0000;
    endcase
    return v;
  endfunction

  // round to nearest, ties toward +inf, by a constant shift
  function automatic logic signed [MUL_PW-1:0] rnd_sh(input logic signed [MUL_PW-1:0] v,
                                                      input int unsigned s);
    logic signed [MUL_PW-1:0] half;
    logic signed [MUL_PW-1:0] sum;
    half = MUL_PW'(64'sd1) <<< (s - 1);
    sum  = v + half;
    return sum >>> s;
  endfunction

  function automatic logic signed [POS_W-1:0] sat32(input logic signed [MUL_PW-1:0] v);
    logic signed [POS_W-1:0] r;
    if (v > S32_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < S32_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- sv/ddo_if.sv -----
interface ddo_in_if import ddo_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SPEED_W-1:0] left_speed;
  logic signed [SPEED_W-1:0] right_speed;

  modport source (output valid, output left_speed, output right_speed, input ready);
  modport sink (input valid, input left_speed, input right_speed, output ready);
endinterface

interface ddo_out_if import ddo_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic [ANG_W-1:0]        heading;
  logic [ANG_W-1:0]        left_wheel_angle;
  logic [ANG_W-1:0]        right_wheel_angle;
  logic signed [FWD_W-1:0] forward_step;
  logic signed [ANG_W-1:0] turn_step;

  modport source (output valid, output pos_x, output pos_y, output heading,
                  output left_wheel_angle, output right_wheel_angle,
                  output forward_step, output turn_step, input ready);
  modport sink (input valid, input pos_x, input pos_y, input heading,
                input left_wheel_angle, input right_wheel_angle,
                input forward_step, input turn_step, output ready);
endinterface

interface ddo_cfg_if import ddo_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] reg_idx;
  logic [CFG_W-1:0] wdata;

  modport source (output valid, output reg_idx, output wdata, input ready);
  modport sink (input valid, input reg_idx, input wdata, output ready);
endinterface

// ----- sv/ddo_mul.sv -----
module ddo_mul import ddo_pkg::*; (
  input  logic                     clk_i,
  input  logic signed [MUL_AW-1:0] a_i,
  input  logic signed [MUL_BW-1:0] b_i,
  output logic signed [MUL_PW-1:0] p_o
);

  logic signed [MUL_PW-1:0] p_d, p_q;

  // full signed product, registered
  assign p_d = a_i * b_i;

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

// ----- sv/ddo_cordic.sv -----
module ddo_cordic import ddo_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [ANG_W-1:0]        angle_i,
  output logic                    done_o,
  output logic signed [ANG_W-1:0] cos_o,
  output logic signed [ANG_W-1:0] sin_o
);

  localparam int unsigned CntW = $clog2(CORDIC_STEPS);
  localparam logic [CntW-1:0] LastCnt = CntW'(CORDIC_STEPS - 1);

  logic                    busy_d, busy_q;
  logic                    done_d, done_q;
  logic [CntW-1:0]         cnt_d, cnt_q;
  logic                    neg_d, neg_q;
  logic signed [CRD_W-1:0] x_d, x_q, y_d, y_q, z_d, z_q;
  logic signed [CRD_W-1:0] za, x_sh, y_sh, at;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    done_d = 1'b0;
    za     = CRD_W'($signed(angle_i));
    x_sh   = x_q >>> cnt_q;
    y_sh   = y_q >>> cnt_q;
    at     = $signed({2'b00, atan_lut(5'(cnt_q))});
    if (start_i) begin
      // fold headings beyond a quarter turn onto the right half plane
      if (za > Q_TURN || za < -Q_TURN) begin
        z_d   = (za >= 0) ? za - H_TURN : za + H_TURN;
        neg_d = 1'b1;
      end else begin
        z_d   = za;
        neg_d = 1'b0;
      end
      x_d    = CORDIC_X0;
      y_d    = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!z_q[CRD_W-1]) begin
        x_d = x_q - y_sh;
        y_d = y_q + x_sh;
        z_d = z_q - at;
      end else begin
        x_d = x_q + y_sh;
        y_d = y_q - x_sh;
        z_d = z_q + at;
      end
      if (cnt_q == LastCnt) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    x_q   <= x_d;
    y_q   <= y_d;
    z_q   <= z_d;
  end

  assign done_o = done_q;
  assign cos_o  = neg_q ? ANG_W'(-x_q) : ANG_W'(x_q);
  assign sin_o  = neg_q ? ANG_W'(-y_q) : ANG_W'(y_q);

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q)
    else $error("cordic done without a finished run");

  a_no_restart_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !start_i && cnt_q != LastCnt) |=> busy_q)
    else $error("cordic run stopped early");

  a_count_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !start_i && cnt_q != LastCnt) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("cordic step counter skipped");

endmodule

// ----- sv/diff_drive_odometry_top.sv -----
// each input item is processed by the sequencer walking nine shared multiplies and the
//   cordic rotations; input ready only while the sequencer idles, so a new item is
//   taken only after the last one is through; a finished result waits in the output
//   register while the next item is taken
// reset: asynchronous active low, clears pose and wheel angles, loads register defaults
module diff_drive_odometry_top import ddo_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  ddo_in_if.sink    in_i,
  ddo_out_if.source out_o,
  ddo_cfg_if.sink   cfg_i
);

  state_e state_d, state_q;

  // configuration registers
  logic [CFG_W-1:0] sd_q, hg_q, wg_q;

  // latched input speeds
  logic signed [SPEED_W-1:0] l_q, r_q;

  // per-item intermediates
  logic signed [TW_W-1:0]  tw_l_q, tw_r_q;
  logic signed [FWD_W-1:0] fwd_q;
  logic signed [TD_W-1:0]  td_q;
  logic signed [POS_W-1:0] turn_q;

  // accumulated state
  logic [ANG_W-1:0]        heading_q, left_acc_q, right_acc_q;
  logic signed [POS_W-1:0] x_acc_q, y_acc_q;

  // output register
  logic                    out_valid_d, out_valid_q;
  logic signed [POS_W-1:0] o_x_q, o_y_q;
  logic [ANG_W-1:0]        o_head_q, o_left_q, o_right_q;
  logic signed [FWD_W-1:0] o_fwd_q;
  logic signed [ANG_W-1:0] o_turn_q;
  logic                    out_load;

  // shared multiplier operands and product
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [MUL_PW-1:0] prod;

  // rounded product views, one per shift used
  logic signed [MUL_PW-1:0] rnd12, rnd14, rnd15, rnd38;
  logic signed [MUL_PW-1:0] x_sum, y_sum;
  logic signed [POS_W-1:0]  turn_sat;

  logic signed [SPEED_W:0]  lr_sum, rl_dif;
  logic signed [MUL_BW-1:0] sd_ext, hg_ext, wg_ext;

  // cordic handshake
  logic                    cor_start, cor_done;
  logic signed [ANG_W-1:0] cor_cos, cor_sin;

  logic in_acc;

  assign in_acc   = in_i.valid && in_i.ready;
  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  assign lr_sum = (SPEED_W + 1)'(l_q) + (SPEED_W + 1)'(r_q);
  assign rl_dif = (SPEED_W + 1)'(r_q) - (SPEED_W + 1)'(l_q);
  assign sd_ext = $signed({{(MUL_BW - CFG_W){1'b0}}, sd_q});
  assign hg_ext = $signed({{(MUL_BW - CFG_W){1'b0}}, hg_q});
  assign wg_ext = $signed({{(MUL_BW - CFG_W){1'b0}}, wg_q});

  assign rnd12    = rnd_sh(prod, 12);
  assign rnd14    = rnd_sh(prod, 14);
  assign rnd15    = rnd_sh(prod, 15);
  assign rnd38    = rnd_sh(prod, 38);
  assign turn_sat = sat32(rnd12);
  assign x_sum    = MUL_PW'(x_acc_q) + rnd38;
  assign y_sum    = MUL_PW'(y_acc_q) + rnd38;

  assign cor_start = (state_q == ST_CSTART);
  assign out_load  = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);

  // operand select: each state issues the multiply whose product the next state uses
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_MUL_L: begin
        mul_a = MUL_AW'(l_q);
        mul_b = sd_ext;
      end
      ST_MUL_R: begin
        mul_a = MUL_AW'(r_q);
        mul_b = sd_ext;
      end
      ST_ANG_L: begin
        mul_a = MUL_AW'(tw_l_q);
        mul_b = wg_ext;
      end
      ST_ANG_R: begin
        mul_a = MUL_AW'(tw_r_q);
        mul_b = wg_ext;
      end
      ST_FWD: begin
        mul_a = MUL_AW'(lr_sum);
        mul_b = sd_ext;
      end
      ST_DIFF: begin
        mul_a = MUL_AW'(rl_dif);
        mul_b = sd_ext;
      end
      ST_GAIN: begin
        mul_a = MUL_AW'(td_q);
        mul_b = hg_ext;
      end
      ST_MULX: begin
        mul_a = MUL_AW'(fwd_q);
        mul_b = MUL_BW'(cor_cos);
      end
      ST_MULY: begin
        mul_a = MUL_AW'(fwd_q);
        mul_b = MUL_BW'(cor_sin);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_acc) state_d = ST_MUL_L;
      ST_MUL_L:  state_d = ST_MUL_R;
      ST_MUL_R:  state_d = ST_ANG_L;
      ST_ANG_L:  state_d = ST_ANG_R;
      ST_ANG_R:  state_d = ST_FWD;
      ST_FWD:    state_d = ST_DIFF;
      ST_DIFF:   state_d = ST_TD;
      ST_TD:     state_d = ST_GAIN;
      ST_GAIN:   state_d = ST_TURN;
      ST_TURN:   state_d = ST_CSTART;
      ST_CSTART: state_d = ST_CWAIT;
      ST_CWAIT:  if (cor_done) state_d = ST_MULX;
      ST_MULX:   state_d = ST_MULY;
      ST_MULY:   state_d = ST_POSY;
      ST_POSY:   state_d = ST_DONE;
      ST_DONE:   if (out_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // control, configuration and accumulated pose
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      sd_q        <= STEP_DIST_RST;
      hg_q        <= HEAD_GAIN_RST;
      wg_q        <= WHEEL_GAIN_RST;
      heading_q   <= '0;
      left_acc_q  <= '0;
      right_acc_q <= '0;
      x_acc_q     <= '0;
      y_acc_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      // writes beyond the register list fall through and are dropped
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_i.reg_idx)
          CFG_STEP_DIST:  sd_q <= cfg_i.wdata;
          CFG_HEAD_GAIN:  hg_q <= cfg_i.wdata;
          CFG_WHEEL_GAIN: wg_q <= cfg_i.wdata;
          default: ;
        endcase
      end
      // wheel angles wrap modulo one turn
      if (state_q == ST_ANG_R) left_acc_q  <= left_acc_q + rnd12[ANG_W-1:0];
      if (state_q == ST_FWD)   right_acc_q <= right_acc_q + rnd12[ANG_W-1:0];
      // heading moves first, the cordic then sees the new value
      if (state_q == ST_TURN)  heading_q   <= heading_q + ANG_W'(turn_sat);
      if (state_q == ST_MULY)  x_acc_q     <= sat32(x_sum);
      if (state_q == ST_POSY)  y_acc_q     <= sat32(y_sum);
    end
  end

  // per-item payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      l_q <= in_i.left_speed;
      r_q <= in_i.right_speed;
    end
    if (state_q == ST_MUL_R) tw_l_q <= rnd14[TW_W-1:0];
    if (state_q == ST_ANG_L) tw_r_q <= rnd14[TW_W-1:0];
    if (state_q == ST_DIFF)  fwd_q  <= rnd15[FWD_W-1:0];
    if (state_q == ST_TD)    td_q   <= rnd14[TD_W-1:0];
    if (state_q == ST_TURN)  turn_q <= turn_sat;
    if (out_load) begin
      o_x_q     <= x_acc_q;
      o_y_q     <= y_acc_q;
      o_head_q  <= heading_q;
      o_left_q  <= left_acc_q;
      o_right_q <= right_acc_q;
      o_fwd_q   <= fwd_q;
      o_turn_q  <= turn_q;
    end
  end

  ddo_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  ddo_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .angle_i (heading_q),
    .done_o  (cor_done),
    .cos_o   (cor_cos),
    .sin_o   (cor_sin)
  );

  assign out_o.valid             = out_valid_q;
  assign out_o.pos_x             = o_x_q;
  assign out_o.pos_y             = o_y_q;
  assign out_o.heading           = o_head_q;
  assign out_o.left_wheel_angle  = o_left_q;
  assign out_o.right_wheel_angle = o_right_q;
  assign out_o.forward_step      = o_fwd_q;
  assign out_o.turn_step         = o_turn_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_MUL_L)
    else $error("accepted item did not start the sequencer");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cor_done |-> state_q == ST_CWAIT)
    else $error("cordic finished outside its wait state");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_valid_q && !out_o.ready) |=> state_q == ST_DONE)
    else $error("pending result would be overwritten");

  a_heading_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_TURN) |=> $stable(heading_q))
    else $error("heading changed outside the turn update");

endmodule
